@@ src/ewaw_pkg.sv @@
// Shared codes, controller states and control/status bundles for the event wait unit.
package ewaw_pkg;

    localparam logic [1:0] OP_AWAIT   = 2'd0;
    localparam logic [1:0] OP_TRIGGER = 2'd1;
    localparam logic [1:0] OP_CANCEL  = 2'd2;

    localparam logic [2:0] KIND_GOT       = 3'd0;
    localparam logic [2:0] KIND_NONE      = 3'd1;
    localparam logic [2:0] KIND_WAITING   = 3'd2;
    localparam logic [2:0] KIND_WOKEN     = 3'd3;
    localparam logic [2:0] KIND_TRIG_DONE = 3'd4;
    localparam logic [2:0] KIND_CANCELLED = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_A_FIND,
        ST_A_TAKE,
        ST_A_MISS,
        ST_T_START,
        ST_T_SCAN,
        ST_T_FIN,
        ST_C_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic       load;
        logic       find;
        logic       take_wr;
        logic       wait_reg;
        logic       cancel;
        logic       scan_start;
        logic       scan_step;
        logic       inc_wr;
        logic       emit;
        logic [2:0] kind;
        logic       last;
    } ewaw_cmd_t;

    typedef struct packed {
        logic [1:0] in_op;
        logic       hit;
        logic       can_wait;
        logic       e_ok;
        logic       scan_hit;
        logic       scan_last;
        logic       none_woken;
        logic       drop;
        logic       out_free;
    } ewaw_stat_t;

endpackage

@@ src/ewaw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module ewaw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/ewaw_ctrl.sv @@
// Controller state machine: sequences awaits, trigger scans and cancels.
module ewaw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  ewaw_pkg::ewaw_stat_t stat,
    output ewaw_pkg::ewaw_cmd_t  cmd
);
    import ewaw_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    case (stat.in_op)
                        OP_AWAIT:   state_next = ST_A_FIND;
                        OP_TRIGGER: state_next = ST_T_START;
                        OP_CANCEL:  state_next = ST_C_DONE;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_A_FIND:
            begin
                cmd.find   = 1'b1;
                state_next = stat.hit ? ST_A_TAKE : ST_A_MISS;
            end
            ST_A_TAKE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.kind    = KIND_GOT;
                    cmd.last    = 1'b1;
                    cmd.take_wr = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_A_MISS:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.last     = 1'b1;
                    cmd.kind     = stat.can_wait ? KIND_WAITING : KIND_NONE;
                    cmd.wait_reg = stat.can_wait;
                    state_next   = ST_IDLE;
                end
            end
            ST_T_START:
            begin
                cmd.scan_start = 1'b1;
                state_next     = stat.e_ok ? ST_T_SCAN : ST_T_FIN;
            end
            ST_T_SCAN:
            begin
                if (!stat.scan_hit || stat.out_free)
                begin
                    cmd.scan_step = 1'b1;
                    cmd.emit      = stat.scan_hit;
                    cmd.kind      = KIND_WOKEN;
                    if (stat.scan_last)
                    begin
                        state_next = ST_T_FIN;
                    end
                end
            end
            ST_T_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_TRIG_DONE;
                    cmd.last   = 1'b1;
                    cmd.inc_wr = stat.e_ok && stat.none_woken && !stat.drop;
                    state_next = ST_IDLE;
                end
            end
            ST_C_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = KIND_CANCELLED;
                    cmd.last   = 1'b1;
                    cmd.cancel = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/ewaw_dp.sv @@
// Datapath: item registers, pending-count and wait-mask memories, result register.
module ewaw_dp #(
    parameter int N_EVENTS    = 32,
    parameter int NUM_THREADS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           in_op,
    input  logic [3:0]           in_thread_id,
    input  logic [31:0]          in_event_mask,
    input  logic                 in_block,
    input  logic [4:0]           in_event_id,
    input  logic                 in_drop,
    input  ewaw_pkg::ewaw_cmd_t  cmd,
    output ewaw_pkg::ewaw_stat_t stat,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic [2:0]           out_kind,
    output logic [3:0]           out_who,
    output logic [4:0]           out_event_index,
    output logic [4:0]           out_woken_count,
    output logic                 out_last
);
    import ewaw_pkg::*;

    localparam int EW = $clog2(N_EVENTS);
    localparam int TW = $clog2(NUM_THREADS);
    localparam int CW = $clog2(NUM_THREADS + 1);

    // captured item
    logic [1:0]            op_reg;
    logic [3:0]            tid_reg;
    logic [N_EVENTS-1:0]   evm_reg;
    logic                  block_reg;
    logic [4:0]            eid_reg;
    logic                  drop_reg;

    logic [EW-1:0]          idx_reg;
    logic [TW-1:0]          scan_idx_reg;
    logic [CW-1:0]          cnt_reg;
    logic [N_EVENTS-1:0]    nz_reg;      // pending count nonzero
    logic [NUM_THREADS-1:0] wvalid_reg;  // thread has a live wait mask

    logic                  out_valid_reg;
    logic [2:0]            kind_reg;
    logic [3:0]            who_reg;
    logic [4:0]            evx_reg;
    logic [4:0]            wc_reg;
    logic                  last_reg;

    logic [63:0]           mask64;
    logic [31:0]           tid32;
    logic [31:0]           eid32;
    logic [31:0]           idx32;
    logic [31:0]           scan32;
    logic [31:0]           cnt32;
    logic [TW-1:0]         tidx;
    logic [EW-1:0]         eidx;
    logic                  t_ok;
    logic                  e_ok;
    logic [N_EVENTS-1:0]   cand;
    logic [EW-1:0]         found;

    logic                  p_we;
    logic [EW-1:0]         p_waddr;
    logic [COUNT_BITS-1:0] p_wdata;
    logic [EW-1:0]         p_raddr;
    logic [COUNT_BITS-1:0] p_rdata;
    logic [N_EVENTS-1:0]   w_rdata;
    logic [TW-1:0]         w_raddr;

    logic [3:0]            who_new;
    logic [4:0]            evx_new;
    logic [4:0]            wc_new;

    assign mask64 = 64'(in_event_mask);
    assign tid32  = 32'(tid_reg);
    assign eid32  = 32'(eid_reg);
    assign idx32  = 32'(idx_reg);
    assign scan32 = 32'(scan_idx_reg);
    assign cnt32  = 32'(cnt_reg);
    assign tidx   = tid32[TW-1:0];
    assign eidx   = eid32[EW-1:0];
    assign t_ok   = tid32 < 32'(NUM_THREADS);
    assign e_ok   = eid32 < 32'(N_EVENTS);

    // lowest pending event in the await mask
    assign cand = evm_reg & nz_reg;
    always_comb
    begin
        found = '0;
        for (int i = N_EVENTS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                found = EW'(i);
            end
        end
    end

    assign stat.in_op      = in_op;
    assign stat.hit        = |cand;
    assign stat.can_wait   = block_reg && (|evm_reg) && t_ok;
    assign stat.e_ok       = e_ok;
    assign stat.scan_hit   = wvalid_reg[scan_idx_reg] && w_rdata[eidx];
    assign stat.scan_last  = scan_idx_reg == TW'(NUM_THREADS - 1);
    assign stat.none_woken = cnt_reg == '0;
    assign stat.drop       = drop_reg;
    assign stat.out_free   = !out_valid_reg || out_ready;

    // pending counts
    assign p_raddr = cmd.find ? found : ((op_reg == OP_AWAIT) ? idx_reg : eidx);
    assign p_we    = cmd.take_wr || cmd.inc_wr;
    assign p_waddr = cmd.take_wr ? idx_reg : eidx;
    always_comb
    begin
        if (cmd.take_wr)
        begin
            p_wdata = p_rdata - COUNT_BITS'(1);
        end
        else if (!nz_reg[eidx])
        begin
            p_wdata = COUNT_BITS'(1);
        end
        else if (p_rdata == '1)
        begin
            p_wdata = p_rdata;
        end
        else
        begin
            p_wdata = p_rdata + COUNT_BITS'(1);
        end
    end

    ewaw_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (N_EVENTS)
    ) u_pend_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    // wait masks; address leads the scan index by one while advancing
    always_comb
    begin
        if (cmd.scan_start)
        begin
            w_raddr = '0;
        end
        else if (cmd.scan_step && !stat.scan_last)
        begin
            w_raddr = scan_idx_reg + TW'(1);
        end
        else
        begin
            w_raddr = scan_idx_reg;
        end
    end

    ewaw_ram #(
        .WIDTH (N_EVENTS),
        .DEPTH (NUM_THREADS)
    ) u_wait_ram (
        .clk   (clk),
        .we    (cmd.wait_reg),
        .waddr (tidx),
        .wdata (evm_reg),
        .raddr (w_raddr),
        .rdata (w_rdata)
    );

    always_comb
    begin
        who_new = tid_reg;
        evx_new = '0;
        wc_new  = '0;
        case (cmd.kind)
            KIND_GOT:
            begin
                evx_new = idx32[4:0];
            end
            KIND_WOKEN:
            begin
                who_new = scan32[3:0];
                evx_new = eid_reg;
            end
            KIND_TRIG_DONE:
            begin
                who_new = '0;
                evx_new = eid_reg;
                wc_new  = cnt32[4:0];
            end
            default:
            begin
                who_new = tid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nz_reg        <= '0;
            wvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take_wr && p_rdata == COUNT_BITS'(1))
            begin
                nz_reg[idx_reg] <= 1'b0;
            end
            if (cmd.inc_wr)
            begin
                nz_reg[eidx] <= 1'b1;
            end
            if ((cmd.find || cmd.cancel) && t_ok)
            begin
                wvalid_reg[tidx] <= 1'b0;
            end
            if (cmd.wait_reg)
            begin
                wvalid_reg[tidx] <= 1'b1;
            end
            if (cmd.scan_step && stat.scan_hit)
            begin
                wvalid_reg[scan_idx_reg] <= 1'b0;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_op;
            tid_reg   <= in_thread_id;
            evm_reg   <= mask64[N_EVENTS-1:0];
            block_reg <= in_block;
            eid_reg   <= in_event_id;
            drop_reg  <= in_drop;
        end
        if (cmd.find)
        begin
            idx_reg <= found;
        end
        if (cmd.scan_start)
        begin
            scan_idx_reg <= '0;
            cnt_reg      <= '0;
        end
        else if (cmd.scan_step)
        begin
            if (!stat.scan_last)
            begin
                scan_idx_reg <= scan_idx_reg + TW'(1);
            end
            if (stat.scan_hit)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
        end
        if (cmd.emit)
        begin
            kind_reg <= cmd.kind;
            who_reg  <= who_new;
            evx_reg  <= evx_new;
            wc_reg   <= wc_new;
            last_reg <= cmd.last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_kind        = kind_reg;
    assign out_who         = who_reg;
    assign out_event_index = evx_reg;
    assign out_woken_count = wc_reg;
    assign out_last        = last_reg;

endmodule

@@ src/event_wait_any_wake_unit.sv @@
// Top level of the event wait-any / wake unit.
//
//  channel | dir | tdata (low bit up)                                 | tuser | tlast
//  s_*     | in  | thread_id[3:0] event_mask[35:4] block[36]         | op    | -
//          |     | event_id[41:37] drop[42], zero fill to 48          |       |
//  m_*     | out | who[3:0] event_index[8:4] woken_count[13:9],       | kind  | last
//          |     | zero fill to 16                                    |       |
//
// An await runs find, then take or miss; a cancel runs done; a trigger runs start, a
// scan of the wait-mask memory (one thread per cycle unless a wake is stalled), finish.
// One transaction is worked on at a time; s_tready is high only while the unit is idle.
// The result register lets the next transaction in while the last result waits.
// Reset clears the per-event nonzero flags and the per-thread wait-valid flags, so
// neither memory needs a clearing pass.
module event_wait_any_wake_unit #(
    parameter int N_EVENTS    = 32,
    parameter int NUM_THREADS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // thread_id, event_mask, block, event_id, drop
    input  logic [1:0]  s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // who, event_index, woken_count
    output logic [2:0]  m_tuser,   // kind
    output logic        m_tlast
);
    import ewaw_pkg::*;

    ewaw_cmd_t  cmd;
    ewaw_stat_t stat;

    logic [3:0] who;
    logic [4:0] event_index;
    logic [4:0] woken_count;

    ewaw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ewaw_dp #(
        .N_EVENTS    (N_EVENTS),
        .NUM_THREADS (NUM_THREADS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_op           (s_tuser),
        .in_thread_id    (s_tdata[3:0]),
        .in_event_mask   (s_tdata[35:4]),
        .in_block        (s_tdata[36]),
        .in_event_id     (s_tdata[41:37]),
        .in_drop         (s_tdata[42]),
        .cmd             (cmd),
        .stat            (stat),
        .out_ready       (m_tready),
        .out_valid       (m_tvalid),
        .out_kind        (m_tuser),
        .out_who         (who),
        .out_event_index (event_index),
        .out_woken_count (woken_count),
        .out_last        (m_tlast)
    );

    assign m_tdata = {2'b00, woken_count, event_index, who};

endmodule

@@ src/ewaw_checker.sv @@
// Port-level assertions for the event wait unit, bound to the top level.
module ewaw_sva (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import ewaw_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // one transaction at a time; the unused op code is dropped on the spot
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_AWAIT || s_tuser == OP_TRIGGER
            || s_tuser == OP_CANCEL) |=> !s_tready)
        else $error("input taken while busy");

    // only wake results are not final
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser != KIND_WOKEN)))
        else $error("tlast does not match result kind");

    // woken count only on trigger done
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_TRIG_DONE |-> m_tdata[13:9] == 5'd0)
        else $error("woken count on non-trigger result");

endmodule

bind event_wait_any_wake_unit ewaw_sva u_ewaw_sva (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
